@@ hdl/sha_pkg.sv @@
package sha_pkg;

    // request commands
    localparam logic [1:0] CMD_ABSORB        = 2'd0;
    localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH        = 2'd2;

    localparam int BLOCK_BITS  = 512;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_t;

    // one 64-byte block for the compressor, byte 0 in the top bits
    typedef struct packed {
        logic [BLOCK_BITS-1:0] block;
        logic                  final_blk;
    } job_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

@@ hdl/sha_front.sv @@
module sha_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          msg_valid,
    output logic          msg_ready,
    input  sha_pkg::msg_t msg,
    input  logic          q_full,
    output logic          q_push,
    output sha_pkg::job_t q_job
);
    import sha_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MARK, F_ZERO, F_LEN} fstate_t;

    fstate_t               state_reg, state_next;
    logic [5:0]            fill_reg, fill_next;
    logic [63:0]           total_reg, total_next;
    logic [2:0]            len_idx_reg, len_idx_next;
    logic [BLOCK_BITS-1:0] block_reg, block_next;

    logic        can_shift;
    logic        shift_en;
    logic [7:0]  shift_byte;
    logic [63:0] len_bits;

    // a byte that completes a block needs room in the queue
    assign can_shift = (fill_reg != 6'd63) || !q_full;
    assign msg_ready = (state_reg == F_IDLE) && can_shift;
    assign len_bits  = {total_reg[60:0], 3'b000};

    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        len_idx_next = len_idx_reg;
        shift_en     = 1'b0;
        shift_byte   = msg.data_byte;
        case (state_reg)
            F_IDLE:
            begin
                if (msg_valid && msg_ready)
                begin
                    if (msg.cmd == CMD_ABSORB || msg.cmd == CMD_ABSORB_FINISH)
                    begin
                        shift_en   = 1'b1;
                        total_next = total_reg + 64'd1;
                    end
                    if (msg.cmd == CMD_ABSORB_FINISH || msg.cmd == CMD_FINISH)
                    begin
                        state_next = F_MARK;
                    end
                end
            end
            F_MARK:
            begin
                if (can_shift)
                begin
                    shift_en   = 1'b1;
                    shift_byte = PAD_MARK;
                    state_next = F_ZERO;
                end
            end
            F_ZERO:
            begin
                if (fill_reg == LEN_POS)
                begin
                    state_next   = F_LEN;
                    len_idx_next = 3'd0;
                end
                else if (can_shift)
                begin
                    shift_en   = 1'b1;
                    shift_byte = 8'h00;
                end
            end
            F_LEN:
            begin
                if (can_shift)
                begin
                    shift_en     = 1'b1;
                    shift_byte   = len_bits[{~len_idx_reg, 3'b000} +: 8];
                    len_idx_next = len_idx_reg + 3'd1;
                    if (len_idx_reg == 3'd7)
                    begin
                        state_next = F_IDLE;
                        total_next = 64'd0;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign block_next = shift_en ? {block_reg[BLOCK_BITS-9:0], shift_byte} : block_reg;
    assign fill_next  = shift_en ? fill_reg + 6'd1 : fill_reg;

    assign q_push          = shift_en && (fill_reg == 6'd63);
    assign q_job.block     = block_next;
    assign q_job.final_blk = (state_reg == F_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            fill_reg    <= 6'd0;
            total_reg   <= 64'd0;
            len_idx_reg <= 3'd0;
            block_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            len_idx_reg <= len_idx_next;
            block_reg   <= block_next;
        end
    end

endmodule

@@ hdl/sha_queue.sv @@
module sha_queue #(
    parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sha_pkg::job_t job_in,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output sha_pkg::job_t job_out
);
    import sha_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign job_out = entries_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/sha_back.sv @@
module sha_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  sha_pkg::job_t    q_job,
    output logic             q_pop,
    output logic             digest_valid,
    input  logic             digest_ready,
    output sha_pkg::digest_t digest
);
    import sha_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_ROUND, B_ADD, B_EMIT} bstate_t;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    bstate_t     state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic        final_reg, final_next;
    logic [2:0]  word_idx_reg, word_idx_next;
    logic        out_valid_reg, out_valid_next;
    digest_t     out_reg, out_next;
    logic [31:0] win_reg   [16];
    logic [31:0] win_next  [16];
    logic [31:0] vars_reg  [8];
    logic [31:0] vars_next [8];
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next[8];

    logic        emit_free;
    logic [31:0] t1, t2, w_new;

    assign emit_free    = !out_valid_reg || digest_ready;
    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    // message schedule: window holds w[t..t+15]
    assign w_new = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign t1 = vars_reg[7] + bsig1(vars_reg[4])
              + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
              + round_k(round_reg) + win_reg[0];
    assign t2 = bsig0(vars_reg[0])
              + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]));

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        final_next     = final_reg;
        word_idx_next  = word_idx_reg;
        out_next       = out_reg;
        win_next       = win_reg;
        vars_next      = vars_reg;
        chain_next     = chain_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg && !digest_ready;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    for (int i = 0; i < 16; i++)
                    begin
                        win_next[i] = q_job.block[32*(15-i) +: 32];
                    end
                    vars_next  = chain_reg;
                    final_next = q_job.final_blk;
                    round_next = 6'd0;
                    state_next = B_ROUND;
                end
            end
            B_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = w_new;
                vars_next[0] = t1 + t2;
                vars_next[1] = vars_reg[0];
                vars_next[2] = vars_reg[1];
                vars_next[3] = vars_reg[2];
                vars_next[4] = vars_reg[3] + t1;
                vars_next[5] = vars_reg[4];
                vars_next[6] = vars_reg[5];
                vars_next[7] = vars_reg[6];
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = B_ADD;
                end
            end
            B_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                end
                word_idx_next = 3'd0;
                state_next    = final_reg ? B_EMIT : B_IDLE;
            end
            B_EMIT:
            begin
                if (emit_free)
                begin
                    out_next.digest_word = chain_reg[word_idx_reg];
                    out_next.word_index  = word_idx_reg;
                    out_next.last_word   = (word_idx_reg == 3'd7);
                    out_valid_next       = 1'b1;
                    word_idx_next        = word_idx_reg + 3'd1;
                    if (word_idx_reg == 3'd7)
                    begin
                        chain_next = INIT_H;
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            round_reg     <= 6'd0;
            final_reg     <= 1'b0;
            word_idx_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            win_reg       <= '{default: '0};
            vars_reg      <= '{default: '0};
            chain_reg     <= INIT_H;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            final_reg     <= final_next;
            word_idx_reg  <= word_idx_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            win_reg       <= win_next;
            vars_reg      <= vars_next;
            chain_reg     <= chain_next;
        end
    end

endmodule

@@ hdl/sha256_message_hasher.sv @@
// Throughput: one byte request a cycle while the front is not padding and the
//   queue has room; per block, the one-round compressor loads, runs 64 rounds
//   and adds the chain.
// Finish: while the queue has room, the front pads one byte a cycle (mark, zeros
//   to byte 56, a step to see byte 56, 8 length bytes), then the back compresses
//   each queued block and sends one digest word a cycle while the receiver is ready.
// Reset (rst_n low, asynchronous): chain = initial hash, counts zero, queue empty.
module sha256_message_hasher #(
    parameter int Q_DEPTH = sha_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             msg_valid,
    output logic             msg_ready,
    input  sha_pkg::msg_t    msg,
    output logic             digest_valid,
    input  logic             digest_ready,
    output sha_pkg::digest_t digest
);
    import sha_pkg::*;

    // Front: takes byte requests, packs them into a 64-byte shift line and,
    // on a finish command, appends the padding and the bit length itself.
    // Each completed block is handed to the queue, tagged when it is the last
    // block of a message.
    logic q_full;
    logic q_push;
    job_t q_job_in;

    // Queue: lets the front fill the next block while the back compresses.
    logic q_valid;
    logic q_pop;
    job_t q_job_out;

    sha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job_in)
    );

    sha_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (q_job_in),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .job_out (q_job_out)
    );

    // Back: one compression round a cycle; after a tagged block it sends the
    // eight chain words through the output register and re-arms the chain.
    sha_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_job        (q_job_out),
        .q_pop        (q_pop),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

endmodule

@@ hdl/sha_checker.sv @@
module sha_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             msg_valid,
    input logic             msg_ready,
    input sha_pkg::msg_t    msg,
    input logic             digest_valid,
    input logic             digest_ready,
    input sha_pkg::digest_t digest
);
    import sha_pkg::*;

    // a stalled digest word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest))
        else $error("digest word changed while stalled");

    // the words of one digest follow back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !digest.last_word |=>
            digest_valid && (digest.word_index == 3'($past(digest.word_index) + 3'd1)))
        else $error("digest words out of sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_index == 3'd7)))
        else $error("last flag not on word seven");

    // padding keeps the request side closed
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && (msg.cmd == CMD_FINISH) |=> !msg_ready)
        else $error("request taken during padding");

endmodule

bind sha256_message_hasher sha_checker u_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import sha_pkg::*;

    // cmd 3 is not a command; the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int         LEN_OFFSET = 56;

    localparam int RANDOM_REQS     = 350;
    localparam int HOLD_AFTER_REQS = 80;    // long receiver hold starts after this many
    localparam int HOLD_CYCLES     = 1500;
    localparam int SETTLE_CYCLES   = 300;   // > one compression plus a finish pad
    localparam int MAX_REPORTS     = 10;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] CHAIN_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // lengths that land the pad on either side of the length field and block edge
    localparam int EDGE_LENGTHS [8] = '{55, 56, 57, 63, 64, 65, 119, 128};

    // a request waiting to go out; drain holds it back until all digests are in
    typedef struct packed {
        msg_t req;
        logic drain;
    } queued_req_t;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     msg_valid    = 1'b0;
    logic     msg_ready;
    msg_t     msg          = '0;
    logic     digest_valid;
    logic     digest_ready = 1'b0;
    digest_t  digest;

    queued_req_t pending_reqs [$];
    digest_t     digest_expect [$];

    // hash state of the predictor
    logic [31:0] sha_chain [8];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [63:0] msg_len_bytes;

    int error_count   = 0;
    int accepted_reqs = 0;

    // sender pacing
    int burst_left = 0;
    int gap_left   = 0;

    // receiver pacing
    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    int stall_mode     = 0;
    int mode_left      = 0;
    int rx_phase       = 0;

    sha256_message_hasher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Digest predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] rotr32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic rearm_hash();
        int i;
        for (i = 0; i < 8; i++)
            sha_chain[i] = CHAIN_IV[i];
        block_fill    = 0;
        msg_len_bytes = '0;
    endtask

    // one 64-round compression of msg_block into the chaining words
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (i = 16; i < 64; i++)
        begin
            s0   = rotr32(w[i-15], 7) ^ rotr32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1   = rotr32(w[i-2], 17) ^ rotr32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = sha_chain[0]; b = sha_chain[1]; c = sha_chain[2]; d = sha_chain[3];
        e = sha_chain[4]; f = sha_chain[5]; g = sha_chain[6]; h = sha_chain[7];
        for (i = 0; i < 64; i++)
        begin
            t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25))
                   + ((e & f) ^ (~e & g)) + ROUND_K[i] + w[i];
            t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22))
                   + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        sha_chain[0] += a; sha_chain[1] += b; sha_chain[2] += c; sha_chain[3] += d;
        sha_chain[4] += e; sha_chain[5] += f; sha_chain[6] += g; sha_chain[7] += h;
    endtask

    task automatic absorb_byte(input logic [7:0] data);
        msg_block[block_fill] = data;
        block_fill++;
        msg_len_bytes++;
        if (block_fill == 64)
        begin
            compress_block();
            block_fill = 0;
        end
    endtask

    // pad, append the bit length (mod 2^64), compress, queue eight digest words
    task automatic finish_message();
        logic [63:0] bit_len;
        digest_t     word;
        int          n, i;
        bit_len      = msg_len_bytes << 3;
        n            = block_fill;
        msg_block[n] = PAD_BYTE;
        n++;
        // no room left for the length: spill into a second block
        if (n > LEN_OFFSET)
        begin
            while (n < 64)
            begin
                msg_block[n] = 8'h00;
                n++;
            end
            compress_block();
            n = 0;
        end
        while (n < LEN_OFFSET)
        begin
            msg_block[n] = 8'h00;
            n++;
        end
        for (i = 0; i < 8; i++)
            msg_block[LEN_OFFSET + i] = bit_len[8*(7-i) +: 8];
        compress_block();
        for (i = 0; i < 8; i++)
        begin
            word.digest_word = sha_chain[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            digest_expect.push_back(word);
        end
        rearm_hash();
    endtask

    task automatic hash_request(input msg_t r);
        case (r.cmd)
            CMD_ABSORB:
                absorb_byte(r.data_byte);
            CMD_ABSORB_FINISH:
            begin
                absorb_byte(r.data_byte);
                finish_message();
            end
            CMD_FINISH:
                finish_message();
            default:
                ;   // unused command: no state change, no digest
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps; a drain-flagged request is
    // held back until every outstanding digest word has been seen.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (msg_valid && msg_ready)
            begin
                hash_request(msg);
                accepted_reqs++;
            end
            // payload may only change once the current request has gone
            if (!msg_valid || msg_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    msg_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].drain || digest_expect.size() == 0))
                begin
                    msg       <= pending_reqs[0].req;
                    msg_valid <= 1'b1;
                    pending_reqs.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // now and then a long burst with no idling at all
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    msg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Digest receiver: one long hold-off part way through, otherwise a
    // mix of always-ready, random and periodic stall modes.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && accepted_reqs >= HOLD_AFTER_REQS)
            begin
                hold_left      = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                digest_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 128);
                end
                else
                    mode_left--;
                rx_phase++;
                case (stall_mode)
                    0:       digest_ready <= 1'b1;
                    1:       digest_ready <= 1'($urandom_range(0, 1));
                    2:       digest_ready <= ($urandom_range(0, 3) == 0);
                    default: digest_ready <= ((rx_phase % 5) < 2);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Digest monitor
    // ------------------------------------------------------------------
    task automatic log_error(input string what);
        if (error_count < MAX_REPORTS)
            $display("%t ERROR: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        digest_t want;
        if (rst_n && digest_valid && digest_ready)
        begin
            if (digest_expect.size() == 0)
                log_error($sformatf("unexpected digest word %h idx %0d last %0b",
                                    digest.digest_word, digest.word_index, digest.last_word));
            else
            begin
                want = digest_expect.pop_front();
                if (digest.digest_word !== want.digest_word ||
                    digest.word_index !== want.word_index ||
                    digest.last_word !== want.last_word)
                    log_error($sformatf("expected %h idx %0d last %0b, got %h idx %0d last %0b",
                                        want.digest_word, want.word_index, want.last_word,
                                        digest.digest_word, digest.word_index, digest.last_word));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    task automatic add_request(input logic [1:0] cmd, input logic [7:0] data, input bit drain);
        queued_req_t entry;
        entry.req.cmd       = cmd;
        entry.req.data_byte = data;
        entry.drain         = drain;
        pending_reqs.push_back(entry);
    endtask

    initial
    begin
        int  counted, msgs, len, k, pick;
        bit  finish_on_byte, drain;
        rearm_hash();

        // directed: ignored command at idle, empty message, one-byte messages at
        // the byte extremes, "abc", ignored command mid-message, finish with a
        // non-zero (ignored) byte, and back-to-back empty finishes after re-arm
        add_request(CMD_UNUSED,        8'hA5, 1'b0);
        add_request(CMD_FINISH,        8'h00, 1'b0);
        add_request(CMD_ABSORB_FINISH, 8'h00, 1'b0);
        add_request(CMD_ABSORB,        8'h61, 1'b0);
        add_request(CMD_ABSORB,        8'h62, 1'b0);
        add_request(CMD_ABSORB_FINISH, 8'h63, 1'b0);
        add_request(CMD_ABSORB,        8'hFF, 1'b0);
        add_request(CMD_UNUSED,        8'h5A, 1'b0);
        add_request(CMD_ABSORB,        8'h80, 1'b0);
        add_request(CMD_FINISH,        8'h3C, 1'b0);
        add_request(CMD_ABSORB_FINISH, 8'hFF, 1'b0);
        add_request(CMD_FINISH,        8'hFF, 1'b0);
        add_request(CMD_FINISH,        8'h00, 1'b0);
        add_request(CMD_ABSORB,        8'h01, 1'b0);
        add_request(CMD_ABSORB,        8'hFE, 1'b0);
        add_request(CMD_ABSORB_FINISH, 8'h7F, 1'b0);

        // random messages: mostly short, some on the padding edges, a few long;
        // the second message waits for the pipeline to empty before starting
        counted = 0;
        msgs    = 0;
        while (counted < RANDOM_REQS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
                len = $urandom_range(0, 8);
            else if (pick < 88)
                len = EDGE_LENGTHS[$urandom_range(0, 7)];
            else
                len = $urandom_range(9, 130);
            finish_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
            drain          = (msgs == 1) || ($urandom_range(0, 19) == 0);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    add_request(CMD_UNUSED, 8'($urandom_range(0, 255)), drain);
                    drain = 1'b0;
                end
                add_request((finish_on_byte && k == len - 1) ? CMD_ABSORB_FINISH : CMD_ABSORB,
                            8'($urandom_range(0, 255)), drain);
                drain = 1'b0;
            end
            if (!finish_on_byte)
                add_request(CMD_FINISH, 8'($urandom_range(0, 255)), drain);
            counted += len + (finish_on_byte ? 0 : 1);
            msgs++;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || msg_valid)
            @(posedge clk);
        while (digest_expect.size() != 0)
            @(posedge clk);
        // catch any stray digest words the block might still send
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, many times the slowest legal run
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sha_pkg.sv
hdl/sha_front.sv
hdl/sha_queue.sv
hdl/sha_back.sv
hdl/sha256_message_hasher.sv
hdl/sha_checker.sv
tb/testbench.sv
